[rtl/core/cbd_pkg.sv]
// ---------------------------------------------------------------------------
// cbd_pkg
// Shared types, constants and helpers of the chunked body decoder.
// ---------------------------------------------------------------------------
package cbd_pkg;

  // width of the chunk size counters
  localparam int unsigned SIZE_W = 32;

  // framing characters
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  // decoder phase
  typedef enum logic [2:0] {
    PH_PRE,
    PH_DIGITS,
    PH_SKIP,
    PH_DATA,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_DONE
  } phase_t;

  // one input request as held in the input register
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } item_t;

  // one result as produced by the decode logic
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       has_byte;
    logic       done;
  } result_t;

  // true for 0-9, a-f, A-F
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // nibble value of a hex character, zero for anything else
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

[rtl/core/cbd_in_stage.sv]
// ---------------------------------------------------------------------------
// cbd_in_stage
// Input register: holds one body byte request until the decoder takes it.
// ---------------------------------------------------------------------------
module cbd_in_stage
  import cbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // accept when empty or when the held request leaves this cycle
  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  // occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/core/cbd_core.sv]
// ---------------------------------------------------------------------------
// cbd_core
// Chunk framing state machine: size line parsing, payload count, trailer skip.
// ---------------------------------------------------------------------------
module cbd_core
  import cbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    chunked_mode,
  input  logic    take,
  input  item_t   item,
  output result_t res,
  output phase_t  phase
);

  phase_t              phase_r;
  phase_t              phase_nxt;
  logic [SIZE_W-1:0]   acc_r;
  logic [SIZE_W-1:0]   acc_nxt;
  logic [SIZE_W-1:0]   rem_r;
  logic [SIZE_W-1:0]   rem_nxt;

  phase_t              ph;
  logic [SIZE_W-1:0]   acc;
  logic [SIZE_W-1:0]   rem;
  logic [SIZE_W-1:0]   rem_dec;
  logic                has;
  logic                done;
  logic                emit;

  assign phase = phase_r;

  // body start clears the decoder before the byte is looked at
  always_comb begin
    ph  = item.start ? PH_PRE : phase_r;
    acc = item.start ? '0 : acc_r;
    rem = item.start ? '0 : rem_r;
  end

  assign rem_dec = rem - {{(SIZE_W-1){1'b0}}, 1'b1};

  // next state and result
  always_comb begin
    phase_nxt = ph;
    acc_nxt   = acc;
    rem_nxt   = rem;
    has       = 1'b0;
    done      = 1'b0;
    emit      = 1'b0;
    if (!chunked_mode) begin
      // pass-through: every byte is a result; decoder held but for body start
      has  = 1'b1;
      done = item.last;
      emit = 1'b1;
    end else begin
      unique case (ph)
        PH_PRE, PH_DIGITS, PH_SKIP: begin
          if (item.data == CH_LF) begin
            if (acc == '0) begin
              phase_nxt = PH_DONE;
              done      = 1'b1;
            end else begin
              rem_nxt   = acc;
              acc_nxt   = '0;
              phase_nxt = PH_DATA;
            end
          end else if ((item.data == CH_CR) || (ph == PH_SKIP)) begin
            phase_nxt = ph;
          end else if (is_hex(item.data)) begin
            // saturate once another digit would overflow
            if (|acc[SIZE_W-1 -: 4]) begin
              acc_nxt = '1;
            end else begin
              acc_nxt = {acc[SIZE_W-5:0], hex_val(item.data)};
            end
            phase_nxt = PH_DIGITS;
          end else if ((item.data == CH_SP) && (ph == PH_PRE)) begin
            phase_nxt = ph;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_DATA: begin
          has     = 1'b1;
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_TRAIL1;
          end
        end
        PH_TRAIL1: begin
          phase_nxt = PH_TRAIL2;
        end
        PH_TRAIL2: begin
          phase_nxt = PH_PRE;
          acc_nxt   = '0;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
      // done phase swallows everything, body end included
      if ((ph != PH_DONE) && item.last) begin
        phase_nxt = PH_DONE;
        done      = 1'b1;
      end
      emit = has || done;
    end
  end

  always_comb begin
    res.valid    = emit;
    res.data     = has ? item.data : 8'h00;
    res.has_byte = has;
    res.done     = done;
  end

  // state registers, updated as each request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

[rtl/core/cbd_out_stage.sv]
// ---------------------------------------------------------------------------
// cbd_out_stage
// Result register: holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module cbd_out_stage
  import cbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  result_t res,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    [7:0] out_data,
  output logic    out_has_byte,
  output logic    out_done
);

  logic valid_r;
  logic valid_nxt;
  logic [7:0] data_r;
  logic has_r;
  logic done_r;

  // room for a new result when empty or when the held one leaves now
  assign free = !valid_r || out_ready;

  assign out_valid    = valid_r;
  assign out_data     = data_r;
  assign out_has_byte = has_r;
  assign out_done     = done_r;

  // occupancy
  always_comb begin
    if (take) begin
      valid_nxt = res.valid;
    end else begin
      valid_nxt = valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      data_r <= res.data;
      has_r  <= res.has_byte;
      done_r <= res.done;
    end
  end

endmodule

[rtl/core/chunked_body_decoder.sv]
// ---------------------------------------------------------------------------
// chunked_body_decoder
// Strips HTTP chunked transfer framing from body bytes, up to one a cycle.
// ---------------------------------------------------------------------------
// The decoder takes one body byte per clock unless the output stalls. An
// input register feeds the framing state machine, whose result lands in
// an output register. in_tready drops only while both registers are full
// and out_tready is low. Bytes that are framing (size lines, trailing
// CRLF) give no result; payload bytes, the zero-size chunk and the byte
// marked tlast outside the done phase each give one. With chunked_mode
// clear every byte passes through. Write cfg only while the block is idle.
module chunked_body_decoder
  import cbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,      // chunked_mode
  // body byte stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // in_byte
  input  logic       in_tuser,      // body_start
  input  logic       in_tlast,      // body_end
  // decoded payload stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // out_byte
  output logic       out_tuser,     // has_byte
  output logic       out_tlast      // body_done
);

  logic    mode_r;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_free;
  logic    take;
  result_t res;
  phase_t  phase;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // move a request from the input register into the decoder
  assign take = held_valid && out_free;

  always_comb begin
    in_item.data  = in_tdata;
    in_item.start = in_tuser;
    in_item.last  = in_tlast;
  end

  cbd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  cbd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .chunked_mode (mode_r),
    .take         (take),
    .item         (held_item),
    .res          (res),
    .phase        (phase)
  );

  cbd_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .res          (res),
    .free         (out_free),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata),
    .out_has_byte (out_tuser),
    .out_done     (out_tlast)
  );

  // a result always carries a byte or ends the body
  a_result_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser || out_tlast))
    else $error("result with neither byte nor done");

  // a decoded body end leaves the decoder in the done phase
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (take && mode_r && res.valid && res.done) |=> (phase == PH_DONE))
    else $error("body done without done phase");

  // pass-through turns every request into a result
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !mode_r) |=> out_tvalid)
    else $error("pass-through request lost");

  // nothing leaves the done phase except a body start
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (take && mode_r && (phase == PH_DONE) && !held_item.start) |=> (phase == PH_DONE))
    else $error("left done phase without body start");

endmodule
